>>> src/rgbfb_pkg.sv
// ----------------------------------------------------------------------------
// rgbfb_pkg
// Shared types and constants for the RGB888 to framebuffer blit engine:
// register map, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package rgbfb_pkg;

    // coordinate width used by counters and bound checks
    localparam int COORD_W = 16;

    // apb address width, register i at byte address 4*i
    localparam int PADDR_W = 5;

    // channel length saturation limit
    localparam logic [3:0] MAX_LEN = 4'd8;

    // largest supported bytes per pixel
    localparam logic [2:0] MAX_BPP = 3'd4;

    // register indexes
    typedef enum logic [2:0] {
        REG_LENGTHS = 3'd0,
        REG_OFFSETS = 3'd1,
        REG_BPP     = 3'd2,
        REG_STRIDE  = 3'd3,
        REG_ORIGIN  = 3'd4,
        REG_PIC     = 3'd5,
        REG_SCREEN  = 3'd6
    } reg_idx_t;

    // reset values
    localparam logic [11:0] RST_LENGTHS = 12'd1381;
    localparam logic [14:0] RST_OFFSETS = 15'd11424;
    localparam logic [2:0]  RST_BPP     = 3'd2;
    localparam logic [15:0] RST_STRIDE  = 16'd2048;
    localparam logic [31:0] RST_ORIGIN  = 32'd0;
    localparam logic [31:0] RST_PIC     = 32'd0;
    localparam logic [31:0] RST_SCREEN  = 32'd50332672;

    // decoded configuration seen by the datapath
    typedef struct packed {
        logic [11:0]        lengths;
        logic [14:0]        offsets;
        logic [2:0]         bpp;        // effective, 1..4
        logic [15:0]        stride;
        logic [COORD_W-1:0] ox;
        logic [COORD_W-1:0] oy;
        logic [COORD_W-1:0] pw;
        logic [COORD_W-1:0] ph;
        logic [COORD_W-1:0] sw;
        logic [COORD_W-1:0] sh;
        logic [31:0]        start_base; // oy*stride + ox*bpp
    } cfg_t;

    // per-pixel address result
    typedef struct packed {
        logic        we;
        logic [31:0] addr;
        logic        done;
    } addr_res_t;

endpackage

>>> src/rgb888_to_framebuffer_blit.sv
// ----------------------------------------------------------------------------
// rgb888_to_framebuffer_blit
// RGB888 pixel stream to framebuffer writes: packs each pixel into the
// configured format and gives its byte address and write enable.
//
//   channel  direction  handshake              payload
//   pixel    in         pix_valid / pix_ready  red, green, blue
//   result   out        res_valid / res_ready  write_enable, byte_address,
//                                              pixel_word, picture_done
//   apb      in         psel / penable         paddr, pwdata, prdata
//
// one pixel per clock sustained while res_ready is high; a result passes through
// the two register stages (input register, then result register) after its pixel
// is accepted; the start address multiply is registered in the register file.
// rst_n clears the registers to their reset values and the counters to zero.
// a stall on res_ready holds the result, then the pixel in the input register;
// pix_ready falls only while both are full and res_ready is low.
// ----------------------------------------------------------------------------
module rgb888_to_framebuffer_blit
    import rgbfb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // pixel input
    input  logic               pix_valid,
    output logic               pix_ready,
    input  logic [7:0]         red,
    input  logic [7:0]         green,
    input  logic [7:0]         blue,
    // result output
    output logic               res_valid,
    input  logic               res_ready,
    output logic               write_enable,
    output logic [31:0]        byte_address,
    output logic [31:0]        pixel_word,
    output logic               picture_done
);

    cfg_t       cfg;
    addr_res_t  ares;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [7:0]  red_reg;
    logic [7:0]  green_reg;
    logic [7:0]  blue_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        we_reg;
    logic [31:0] addr_reg;
    logic [31:0] word_reg;
    logic        done_reg;
    logic [31:0] word;
    logic        s1_advance;
    logic        pix_take;

    // configuration registers
    rgbfb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // pixel format packing
    rgbfb_pack u_pack (
        .red     (red_reg),
        .green   (green_reg),
        .blue    (blue_reg),
        .lengths (cfg.lengths),
        .offsets (cfg.offsets),
        .word    (word)
    );

    // address generation
    rgbfb_addr u_addr (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (s1_advance),
        .cfg   (cfg),
        .res   (ares)
    );

    // pipeline handshake
    assign s1_advance     = s1_valid_reg & (~out_valid_reg | res_ready);
    assign pix_ready      = ~s1_valid_reg | s1_advance;
    assign pix_take       = pix_valid & pix_ready;
    assign s1_valid_next  = pix_take | (s1_valid_reg & ~s1_advance);
    assign out_valid_next = s1_advance | (out_valid_reg & ~res_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (pix_take)
        begin
            red_reg   <= red;
            green_reg <= green;
            blue_reg  <= blue;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            we_reg   <= ares.we;
            addr_reg <= ares.addr;
            word_reg <= word;
            done_reg <= ares.done;
        end
    end

    assign res_valid    = out_valid_reg;
    assign write_enable = we_reg;
    assign byte_address = addr_reg;
    assign pixel_word   = word_reg;
    assign picture_done = done_reg;

`ifndef ASSERT_OFF
    // a free result register never blocks the input
    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> pix_ready)
        else $error("input stalled with empty result register");

    // a transaction in stage one reaches the result register next cycle
    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> out_valid_reg)
        else $error("advanced transaction lost");

    // stage one only drains into a free or draining result register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |-> !out_valid_reg || res_ready)
        else $error("result overwritten before taken");
`endif

endmodule

>>> src/rgbfb_cfg.sv
// ----------------------------------------------------------------------------
// rgbfb_cfg
// APB register file; also keeps the picture start address precomputed
// from origin, stride and bytes per pixel.
// ----------------------------------------------------------------------------
module rgbfb_cfg
    import rgbfb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cfg_t               cfg
);

    logic [11:0] lengths_reg;
    logic [14:0] offsets_reg;
    logic [2:0]  bpp_reg;
    logic [15:0] stride_reg;
    logic [31:0] origin_reg;
    logic [31:0] pic_reg;
    logic [31:0] screen_reg;
    logic [31:0] start_base_reg;
    logic [31:0] start_base_next;

    logic                 wr_en;
    reg_idx_t             idx;
    logic [2:0]           bpp_eff;
    logic [COORD_W-1:0]   ox;
    logic [COORD_W-1:0]   oy;
    logic [COORD_W+15:0]  row_prod;
    logic [COORD_W+2:0]   col_prod;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lengths_reg <= RST_LENGTHS;
            offsets_reg <= RST_OFFSETS;
            bpp_reg     <= RST_BPP;
            stride_reg  <= RST_STRIDE;
            origin_reg  <= RST_ORIGIN;
            pic_reg     <= RST_PIC;
            screen_reg  <= RST_SCREEN;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_LENGTHS: lengths_reg <= pwdata[11:0];
                REG_OFFSETS: offsets_reg <= pwdata[14:0];
                REG_BPP:     bpp_reg     <= pwdata[2:0];
                REG_STRIDE:  stride_reg  <= pwdata[15:0];
                REG_ORIGIN:  origin_reg  <= pwdata;
                REG_PIC:     pic_reg     <= pwdata;
                REG_SCREEN:  screen_reg  <= pwdata;
                default:     ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (idx)
            REG_LENGTHS: prdata = {20'd0, lengths_reg};
            REG_OFFSETS: prdata = {17'd0, offsets_reg};
            REG_BPP:     prdata = {29'd0, bpp_reg};
            REG_STRIDE:  prdata = {16'd0, stride_reg};
            REG_ORIGIN:  prdata = origin_reg;
            REG_PIC:     prdata = pic_reg;
            REG_SCREEN:  prdata = screen_reg;
            default:     prdata = 32'd0;
        endcase
    end

    // bytes per pixel clamped to 1..4
    always_comb
    begin
        if (bpp_reg == 3'd0)
            bpp_eff = 3'd1;
        else if (bpp_reg > MAX_BPP)
            bpp_eff = MAX_BPP;
        else
            bpp_eff = bpp_reg;
    end

    assign ox = origin_reg[COORD_W-1:0];
    assign oy = origin_reg[16 +: COORD_W];

    // picture start address, two multiplies and an add, then register
    assign row_prod        = oy * stride_reg;
    assign col_prod        = ox * bpp_eff;
    assign start_base_next = 32'(row_prod) + 32'(col_prod);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            start_base_reg <= 32'd0;
        else
            start_base_reg <= start_base_next;
    end

    // decoded configuration
    always_comb
    begin
        cfg.lengths    = lengths_reg;
        cfg.offsets    = offsets_reg;
        cfg.bpp        = bpp_eff;
        cfg.stride     = stride_reg;
        cfg.ox         = ox;
        cfg.oy         = oy;
        cfg.pw         = pic_reg[COORD_W-1:0];
        cfg.ph         = pic_reg[16 +: COORD_W];
        cfg.sw         = screen_reg[COORD_W-1:0];
        cfg.sh         = screen_reg[16 +: COORD_W];
        cfg.start_base = start_base_reg;
    end

endmodule

>>> src/rgbfb_pack.sv
// ----------------------------------------------------------------------------
// rgbfb_pack
// Packs an RGB888 pixel into a 32-bit framebuffer word using per-channel
// bit lengths and bit offsets.
// ----------------------------------------------------------------------------
module rgbfb_pack
    import rgbfb_pkg::*;
(
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [11:0] lengths,
    input  logic [14:0] offsets,
    output logic [31:0] word
);

    logic [31:0] red_part;
    logic [31:0] green_part;
    logic [31:0] blue_part;

    // truncate to length, then move to offset
    function automatic logic [31:0] place(input logic [7:0] value,
                                          input logic [3:0] len,
                                          input logic [4:0] off);
        logic [3:0] sat_len;
        logic [7:0] cut;
        begin
            sat_len = (len > MAX_LEN) ? MAX_LEN : len;
            cut     = value >> (MAX_LEN - sat_len);
            place   = {24'd0, cut} << off;
        end
    endfunction

    assign red_part   = place(red,   lengths[11:8], offsets[14:10]);
    assign green_part = place(green, lengths[7:4],  offsets[9:5]);
    assign blue_part  = place(blue,  lengths[3:0],  offsets[4:0]);

    assign word = red_part | green_part | blue_part;

endmodule

>>> src/rgbfb_addr.sv
// ----------------------------------------------------------------------------
// rgbfb_addr
// Column and row counters with row base address; gives byte address,
// screen bound write enable and end of picture flag for each pixel.
// ----------------------------------------------------------------------------
module rgbfb_addr
    import rgbfb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  cfg_t      cfg,
    output addr_res_t res
);

    logic [COORD_W-1:0] col_reg;
    logic [COORD_W-1:0] col_next;
    logic [COORD_W-1:0] row_reg;
    logic [COORD_W-1:0] row_next;
    logic [31:0]        row_base_reg;
    logic [31:0]        row_base_next;

    logic               empty;
    logic               at_start;
    logic               last_col;
    logic               last_row;
    logic               in_x;
    logic               in_y;
    logic [31:0]        base_eff;
    logic [COORD_W+1:0] col_bytes;
    logic [COORD_W:0]   col_ext;
    logic [COORD_W:0]   row_ext;

    assign empty    = (cfg.pw == '0) || (cfg.ph == '0);
    assign at_start = (col_reg == '0) && (row_reg == '0);
    assign base_eff = at_start ? cfg.start_base : row_base_reg;
    assign col_ext  = {1'b0, col_reg};
    assign row_ext  = {1'b0, row_reg};

    // column times bytes per pixel
    always_comb
    begin
        unique case (cfg.bpp)
            3'd1:    col_bytes = {2'b00, col_reg};
            3'd2:    col_bytes = {1'b0, col_reg, 1'b0};
            3'd3:    col_bytes = {2'b00, col_reg} + {1'b0, col_reg, 1'b0};
            default: col_bytes = {col_reg, 2'b00};
        endcase
    end

    // bound checks and end of line / picture
    assign in_x     = (col_ext + {1'b0, cfg.ox}) < {1'b0, cfg.sw};
    assign in_y     = (row_ext + {1'b0, cfg.oy}) < {1'b0, cfg.sh};
    assign last_col = (col_ext + 1'b1) >= {1'b0, cfg.pw};
    assign last_row = (row_ext + 1'b1) >= {1'b0, cfg.ph};

    // per-pixel result
    always_comb
    begin
        if (empty)
        begin
            res.we   = 1'b0;
            res.addr = 32'd0;
            res.done = 1'b1;
        end
        else
        begin
            res.we   = in_x & in_y;
            res.addr = base_eff + 32'(col_bytes);
            res.done = last_col & last_row;
        end
    end

    // counter advance
    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        row_base_next = row_base_reg;
        if (empty)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (last_col)
        begin
            col_next = '0;
            if (last_row)
            begin
                row_next      = '0;
                row_base_next = base_eff;
            end
            else
            begin
                row_next      = row_reg + 1'b1;
                row_base_next = base_eff + 32'(cfg.stride);
            end
        end
        else
        begin
            col_next      = col_reg + 1'b1;
            row_base_next = base_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            row_base_reg <= 32'd0;
        end
        else if (step)
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            row_base_reg <= row_base_next;
        end
    end

`ifndef ASSERT_OFF
    // empty picture keeps counters at the origin
    a_empty_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && empty |=> col_reg == '0 && row_reg == '0)
        else $error("counters not cleared on empty picture");

    // last pixel returns to picture start
    a_done_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        step && !empty && last_col && last_row |=> col_reg == '0 && row_reg == '0)
        else $error("counters not reset after last pixel");

    // row only moves at end of line
    a_row_hold: assert property (@(posedge clk) disable iff (!rst_n)
        step && !empty && !last_col |=> row_reg == $past(row_reg))
        else $error("row changed mid-line");

    // counters only move on a transaction
    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(col_reg) && $stable(row_reg) && $stable(row_base_reg))
        else $error("counter state changed without a transaction");
`endif

endmodule
